>>> hw/rtl/mcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared types and constants of the block-header chain allocator.
// ----------------------------------------------------------------------------
package mcb_pkg;

    localparam int unsigned ARENA_PARAGRAPHS_DEF = 4096;
    localparam logic [15:0] BASE_SEG_RESET       = 16'h0100;
    // chain index wide enough for index + size + 1 for arenas of up to 65536 paragraphs
    localparam int unsigned IDX_W                = 17;
    localparam int unsigned HDR_W                = 33;
    localparam logic [15:0] TERM_OWNER           = 16'hffff;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_ADJUST = 2'd1,
        OP_FREE   = 2'd2,
        OP_CHOWN  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    typedef struct packed {
        logic        mark;
        logic [15:0] owner;
        logic [15:0] size;
    } t_hdr;

endpackage

>>> hw/rtl/mcb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mcb_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mcb_chain_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcb_chain_allocator
// First-fit allocator over a chain of block headers kept in one RAM.
// ----------------------------------------------------------------------------
// Sequence: each header visited on the chain is read from RAM, then evaluated;
//   each free block merged adds a read and an evaluate, and each merge run
//   closes with a read and evaluate and a decide step; each header updated is
//   written, with a remainder write on a split; requests add setup, result load.
// Requests are handled one at a time; the RAM read port sets the walk rate.
// Reset: S_INIT0 writes the free block and S_INIT1 the terminator; no request
//   is taken meanwhile. Configuration resets to base segment 0x0100.
// ----------------------------------------------------------------------------
module mcb_chain_allocator #(
    parameter int unsigned ARENA_PARAGRAPHS = mcb_pkg::ARENA_PARAGRAPHS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] operation, [17:2] segment, [33:18] size_paragraphs,
    // [49:34] owner, [55:50] zero
    input  logic [55:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [17:2] result_segment, [33:18] avail_paragraphs,
    // [39:34] zero
    output logic [39:0] o_m_tdata
);
    import mcb_pkg::*;

    localparam int unsigned AW = $clog2(ARENA_PARAGRAPHS);
    localparam logic [IDX_W-1:0] ARENA_END = IDX_W'(ARENA_PARAGRAPHS);

    typedef enum logic [3:0] {
        S_INIT0, S_INIT1, S_IDLE, S_RD, S_EV, S_ABS_RD, S_ABS_EV,
        S_DECIDE, S_WR_CUR, S_WR_REST, S_DONE
    } t_state;

    t_state           r_state;
    logic [15:0]      r_base;
    t_op              r_op;
    logic [15:0]      r_seg, r_req, r_own;
    logic [IDX_W-1:0] r_idx, r_next, r_rest_idx;
    logic             r_rd_ok, r_split, r_cont;
    logic [15:0]      r_howner, r_hsz, r_rest_sz, r_big;
    t_status          r_res_st;
    logic [15:0]      r_res_seg, r_res_avail;
    logic             r_ovalid;
    t_status          r_ostatus;
    logic [15:0]      r_oseg, r_oavail;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    t_hdr             ram_wdata, rd_hdr;
    logic [HDR_W-1:0] ram_rdata;
    logic [IDX_W-1:0] w_nidx;
    logic [16:0]      w_sum;
    logic [15:0]      w_req_eff;
    logic [15:0]      w_cur_seg;
    logic             w_blk, w_accept, w_hit;

    assign rd_hdr    = t_hdr'(ram_rdata);
    assign w_nidx    = r_idx + IDX_W'(r_hsz) + IDX_W'(1);
    assign w_sum     = {1'b0, r_hsz} + {1'b0, rd_hdr.size} + 17'd1;
    assign w_req_eff = (r_op == OP_FREE) ? 16'd0 : r_req;
    assign w_cur_seg = r_base + r_idx[15:0] + 16'd1;
    assign w_blk     = r_rd_ok && rd_hdr.mark;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept  = i_s_tvalid && o_s_tready;

    // flag the header just read as the one the request acts on
    always_comb begin
        unique case (r_op)
            OP_ALLOC:  w_hit = (rd_hdr.owner == 16'd0);
            OP_ADJUST: w_hit = (w_cur_seg == r_seg);
            OP_FREE:   w_hit = (rd_hdr.owner == r_own) && (r_own != 16'd0) &&
                               (rd_hdr.size != 16'd0);
            default:   w_hit = (w_cur_seg == r_seg);
        endcase
    end

    // drive the header RAM from the sequencer state
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_raddr = r_idx[AW-1:0];
        ram_wdata = '{mark: 1'b1, owner: r_howner, size: r_hsz};
        unique case (r_state)
            S_INIT0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{mark: 1'b1, owner: 16'd0,
                              size: 16'(ARENA_PARAGRAPHS - 2)};
            end
            S_INIT1: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(ARENA_PARAGRAPHS - 1);
                ram_wdata = '{mark: 1'b0, owner: TERM_OWNER, size: 16'd0};
            end
            S_RD: begin
                ram_re = (r_idx < ARENA_END);
            end
            S_ABS_RD: begin
                ram_re    = (w_nidx < ARENA_END);
                ram_raddr = w_nidx[AW-1:0];
            end
            S_WR_CUR: begin
                ram_we = 1'b1;
            end
            S_WR_REST: begin
                ram_we    = (r_rest_idx < ARENA_END);
                ram_waddr = r_rest_idx[AW-1:0];
                ram_wdata = '{mark: 1'b1, owner: 16'd0, size: r_rest_sz};
            end
            default: begin
            end
        endcase
    end

    mcb_ram #(
        .WIDTH (HDR_W),
        .DEPTH (ARENA_PARAGRAPHS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer: walk the chain, merge, decide, write back, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT0;
            r_base   <= BASE_SEG_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            // load the result once the output register is free
            if (r_state == S_DONE && (!r_ovalid || i_m_tready)) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= r_res_st;
                r_oseg    <= r_res_seg;
                r_oavail  <= r_res_avail;
            end else if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_INIT0: r_state <= S_INIT1;
                S_INIT1: r_state <= S_IDLE;
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= t_op'(i_s_tdata[1:0]);
                        r_seg   <= i_s_tdata[17:2];
                        r_req   <= i_s_tdata[33:18];
                        r_own   <= i_s_tdata[49:34];
                        r_idx   <= '0;
                        r_big   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rd_ok <= (r_idx < ARENA_END);
                    r_state <= S_EV;
                end
                S_EV: begin
                    r_howner <= (r_op == OP_CHOWN && w_blk && w_hit) ? r_own :
                                rd_hdr.owner;
                    r_hsz    <= rd_hdr.size;
                    r_split  <= 1'b0;
                    r_cont   <= 1'b0;
                    if (!w_blk) begin
                        // end of chain
                        r_res_seg <= '0;
                        r_state   <= S_DONE;
                        unique case (r_op)
                            OP_ALLOC: begin
                                r_res_st <= ST_NOSPACE; r_res_avail <= r_big;
                            end
                            OP_ADJUST: begin
                                r_res_st <= ST_ILLEGAL; r_res_avail <= r_req;
                            end
                            OP_FREE: begin
                                r_res_st <= ST_OK; r_res_avail <= '0;
                            end
                            default: begin
                                r_res_st <= ST_ILLEGAL; r_res_avail <= '0;
                            end
                        endcase
                    end else if (!w_hit) begin
                        // advance to the next header
                        r_idx   <= r_idx + IDX_W'(rd_hdr.size) + IDX_W'(1);
                        r_state <= S_RD;
                    end else begin
                        unique case (r_op) inside
                            OP_ALLOC, OP_FREE: begin
                                r_state <= S_ABS_RD;
                            end
                            OP_ADJUST: begin
                                r_res_seg   <= '0;
                                r_res_avail <= r_req;
                                if (rd_hdr.owner == 16'd0) begin
                                    r_res_st <= ST_ILLEGAL;
                                    r_state  <= S_DONE;
                                end else if (rd_hdr.size == r_req) begin
                                    r_res_st <= ST_OK;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_ABS_RD;
                                end
                            end
                            default: begin
                                r_res_st    <= ST_OK;
                                r_res_seg   <= '0;
                                r_res_avail <= '0;
                                r_state     <= S_WR_CUR;
                            end
                        endcase
                    end
                end
                S_ABS_RD: begin
                    r_rd_ok <= (w_nidx < ARENA_END);
                    r_state <= S_ABS_EV;
                end
                S_ABS_EV: begin
                    // merge the following free block while the size fits
                    if (w_blk && rd_hdr.owner == 16'd0 && !w_sum[16]) begin
                        r_hsz   <= w_sum[15:0];
                        r_state <= S_ABS_RD;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state    <= S_WR_CUR;
                    r_rest_idx <= r_idx + IDX_W'(w_req_eff) + IDX_W'(1);
                    r_rest_sz  <= r_hsz - w_req_eff - 16'd1;
                    if (r_op == OP_ALLOC) begin
                        if (r_hsz >= r_req) begin
                            r_howner    <= r_own;
                            r_hsz       <= r_req;
                            r_split     <= (r_hsz != r_req);
                            r_cont      <= 1'b0;
                            r_next      <= r_idx + IDX_W'(w_req_eff) + IDX_W'(1);
                            r_res_st    <= ST_OK;
                            r_res_seg   <= w_cur_seg;
                            r_res_avail <= r_req;
                        end else begin
                            if (r_hsz > r_big) begin
                                r_big <= r_hsz;
                            end
                            r_split <= 1'b0;
                            r_cont  <= 1'b1;
                            r_next  <= w_nidx;
                        end
                    end else if (w_req_eff > r_hsz) begin
                        r_split     <= 1'b0;
                        r_cont      <= 1'b0;
                        r_next      <= r_idx + IDX_W'(w_req_eff) + IDX_W'(1);
                        r_res_st    <= ST_NOSPACE;
                        r_res_seg   <= '0;
                        r_res_avail <= r_hsz;
                    end else begin
                        r_hsz       <= w_req_eff;
                        r_split     <= (r_hsz != w_req_eff);
                        r_cont      <= (r_op == OP_FREE);
                        r_next      <= r_idx + IDX_W'(w_req_eff) + IDX_W'(1);
                        r_res_st    <= ST_OK;
                        r_res_seg   <= '0;
                        r_res_avail <= w_req_eff;
                    end
                end
                S_WR_CUR, S_WR_REST: begin
                    if (r_state == S_WR_CUR && r_split) begin
                        r_state <= S_WR_REST;
                    end else if (r_cont) begin
                        r_idx   <= r_next;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_oavail, r_oseg, r_ostatus};

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("header RAM written while idle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RD && r_idx == '0))
        else $error("accepted request did not start the walk at the head");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside of completion");

    a_split_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_REST) |-> (r_res_st == ST_OK))
        else $error("remainder written on a failed request");

endmodule
